// ===== src/slt_pkg.sv =====
// Shared types, constants and helpers for the shell line tokenizer.
`default_nettype none

package slt_pkg;

  // Line length limit and the width of the byte counter that reaches it.
  localparam int MAX_LINE = 4096;
  localparam int BP_W     = $clog2(MAX_LINE + 1);
  localparam int POS_W    = 12;
  localparam int RES_MAX  = 3;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Redirection kinds; the token kind is the input redirection plus this.
  localparam logic [1:0] RK_IN     = 2'd0;
  localparam logic [1:0] RK_TRUNC  = 2'd1;
  localparam logic [1:0] RK_APPEND = 2'd2;

  // Scanner modes, one-hot.
  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_WORD   = 6'b000010,
    MODE_QUOTED = 6'b000100,
    MODE_GT     = 6'b001000,
    MODE_RWAIT  = 6'b010000,
    MODE_RNAME  = 6'b100000
  } mode_t;

  typedef enum logic [1:0] {
    EV_CONTENT  = 2'd0,
    EV_COMPLETE = 2'd1,
    EV_ERROR    = 2'd2
  } event_kind_t;

  typedef enum logic [2:0] {
    TK_WORD         = 3'd0,
    TK_QUOTED       = 3'd1,
    TK_PIPE         = 3'd2,
    TK_REDIR_IN     = 3'd3,
    TK_REDIR_TRUNC  = 3'd4,
    TK_REDIR_APPEND = 3'd5
  } token_kind_t;

  typedef enum logic [1:0] {
    ERR_QUOTE     = 2'd0,
    ERR_NO_INPUT  = 2'd1,
    ERR_NO_OUTPUT = 2'd2,
    ERR_TOO_LONG  = 2'd3
  } error_code_t;

  // Line state carried from byte to byte.
  typedef struct packed {
    mode_t             mode;
    logic [1:0]        redir;
    logic [POS_W-1:0]  tok_start;
    logic [POS_W-1:0]  op_pos;
    logic [BP_W-1:0]   byte_pos;
    logic              discard;
  } state_t;

  localparam state_t ST_RESET = '{
    mode:      MODE_IDLE,
    redir:     RK_IN,
    tok_start: '0,
    op_pos:    '0,
    byte_pos:  '0,
    discard:   1'b0
  };

  // One result transaction.
  typedef struct packed {
    event_kind_t       ev;
    token_kind_t       tk;
    logic [7:0]        data;
    logic [POS_W-1:0]  pos;
    error_code_t       err;
    logic              last;
  } result_t;

  // Saturate a byte position to the width of the position field.
  localparam int SAT_W = POS_W + BP_W;
  localparam logic [SAT_W-1:0] POS_MAX_WIDE = SAT_W'((1 << POS_W) - 1);

  function automatic logic [POS_W-1:0] sat_pos(input logic [BP_W-1:0] x);
    logic [SAT_W-1:0] wide;
    wide = SAT_W'(x);
    return (wide > POS_MAX_WIDE) ? POS_MAX_WIDE[POS_W-1:0] : wide[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/slt_step.sv =====
// Combinational step of the tokenizer: one byte in, up to three results out.
`default_nettype none

module slt_step (
  input  wire slt_pkg::state_t  state_i,
  input  wire logic [7:0]       char_i,
  input  wire logic             eol_i,
  output slt_pkg::state_t       state_nxt,
  output slt_pkg::result_t      res_o [slt_pkg::RES_MAX],
  output logic [1:0]            cnt_o
);

  function automatic slt_pkg::result_t mk(input slt_pkg::event_kind_t ev,
                                          input slt_pkg::token_kind_t tk,
                                          input logic [7:0] data,
                                          input logic [slt_pkg::POS_W-1:0] pos,
                                          input slt_pkg::error_code_t err);
    slt_pkg::result_t r;
    r.ev   = ev;
    r.tk   = tk;
    r.data = data;
    r.pos  = pos;
    r.err  = err;
    r.last = 1'b0;
    return r;
  endfunction

  logic                        is_ws;
  logic                        is_sp;
  logic [slt_pkg::POS_W-1:0]   p_sat;

  // Character classes and the current position.
  assign is_ws = (char_i == slt_pkg::CH_SPACE) ||
                 ((char_i >= slt_pkg::CH_TAB) && (char_i <= slt_pkg::CH_CR));
  assign is_sp = (char_i == slt_pkg::CH_PIPE) || (char_i == slt_pkg::CH_LT) ||
                 (char_i == slt_pkg::CH_GT) || (char_i == slt_pkg::CH_QUOTE);
  assign p_sat = slt_pkg::sat_pos(state_i.byte_pos);

  // Scan one byte: a first pass on the current mode, then a second pass when the byte
  // ends a word or name, follows a single '>', or finds idle or a pending redirection.
  always_comb begin
    slt_pkg::state_t        st;
    slt_pkg::result_t       res [slt_pkg::RES_MAX];
    logic [1:0]             n;
    logic                   failed;
    logic                   again;
    slt_pkg::token_kind_t   rtk;

    st     = state_i;
    n      = 2'd0;
    failed = 1'b0;
    again  = 1'b0;
    rtk    = slt_pkg::TK_WORD;
    for (int i = 0; i < slt_pkg::RES_MAX; i++) begin
      res[i] = '0;
    end

    if (state_i.discard) begin
      if (eol_i) begin
        st = slt_pkg::ST_RESET;
      end
    end else begin
      if (state_i.byte_pos >= slt_pkg::BP_W'(slt_pkg::MAX_LINE)) begin
        // Line too long: the byte is not tokenized.
        res[n] = mk(slt_pkg::EV_ERROR, slt_pkg::TK_WORD, 8'h00, p_sat,
                    slt_pkg::ERR_TOO_LONG);
        n = n + 2'd1;
        failed = 1'b1;
      end else begin
        st.byte_pos = state_i.byte_pos + slt_pkg::BP_W'(1);
        rtk = slt_pkg::token_kind_t'(3'(slt_pkg::TK_REDIR_IN) + {1'b0, st.redir});

        // First pass on the mode the byte found.
        unique case (st.mode)
          slt_pkg::MODE_WORD: begin
            if (is_ws || is_sp) begin
              res[n] = mk(slt_pkg::EV_COMPLETE, slt_pkg::TK_WORD, 8'h00,
                          st.tok_start, slt_pkg::ERR_QUOTE);
              n = n + 2'd1;
              st.mode = slt_pkg::MODE_IDLE;
              again = 1'b1;
            end else begin
              res[n] = mk(slt_pkg::EV_CONTENT, slt_pkg::TK_WORD, char_i,
                          st.tok_start, slt_pkg::ERR_QUOTE);
              n = n + 2'd1;
            end
          end
          slt_pkg::MODE_QUOTED: begin
            if (char_i == slt_pkg::CH_QUOTE) begin
              res[n] = mk(slt_pkg::EV_COMPLETE, slt_pkg::TK_QUOTED, 8'h00,
                          st.tok_start, slt_pkg::ERR_QUOTE);
              st.mode = slt_pkg::MODE_IDLE;
            end else begin
              res[n] = mk(slt_pkg::EV_CONTENT, slt_pkg::TK_QUOTED, char_i,
                          st.tok_start, slt_pkg::ERR_QUOTE);
            end
            n = n + 2'd1;
          end
          slt_pkg::MODE_GT: begin
            st.mode = slt_pkg::MODE_RWAIT;
            if (char_i == slt_pkg::CH_GT) begin
              st.redir = slt_pkg::RK_APPEND;
            end else begin
              st.redir = slt_pkg::RK_TRUNC;
              again = 1'b1;
            end
          end
          slt_pkg::MODE_RNAME: begin
            if (is_ws || is_sp) begin
              res[n] = mk(slt_pkg::EV_COMPLETE, rtk, 8'h00, st.tok_start,
                          slt_pkg::ERR_QUOTE);
              n = n + 2'd1;
              st.mode = slt_pkg::MODE_IDLE;
              again = 1'b1;
            end else begin
              res[n] = mk(slt_pkg::EV_CONTENT, rtk, char_i, st.tok_start,
                          slt_pkg::ERR_QUOTE);
              n = n + 2'd1;
            end
          end
          default: begin
            // Between tokens and waiting for a file name: second pass.
            again = 1'b1;
          end
        endcase

        // Second pass: between tokens or waiting for a file name.
        if (again) begin
          rtk = slt_pkg::token_kind_t'(3'(slt_pkg::TK_REDIR_IN) + {1'b0, st.redir});
          unique case (st.mode)
            slt_pkg::MODE_RWAIT: begin
              if (is_sp) begin
                res[n] = mk(slt_pkg::EV_ERROR, slt_pkg::TK_WORD, 8'h00, st.op_pos,
                            (st.redir == slt_pkg::RK_IN) ? slt_pkg::ERR_NO_INPUT
                                                         : slt_pkg::ERR_NO_OUTPUT);
                n = n + 2'd1;
                failed = 1'b1;
              end else if (!is_ws) begin
                st.mode = slt_pkg::MODE_RNAME;
                st.tok_start = p_sat;
                res[n] = mk(slt_pkg::EV_CONTENT, rtk, char_i, p_sat,
                            slt_pkg::ERR_QUOTE);
                n = n + 2'd1;
              end
            end
            default: begin
              st.mode = slt_pkg::MODE_IDLE;
              if (char_i == slt_pkg::CH_QUOTE) begin
                st.mode = slt_pkg::MODE_QUOTED;
                st.tok_start = p_sat;
              end else if (char_i == slt_pkg::CH_PIPE) begin
                res[n] = mk(slt_pkg::EV_COMPLETE, slt_pkg::TK_PIPE, 8'h00, p_sat,
                            slt_pkg::ERR_QUOTE);
                n = n + 2'd1;
              end else if (char_i == slt_pkg::CH_LT) begin
                st.mode = slt_pkg::MODE_RWAIT;
                st.redir = slt_pkg::RK_IN;
                st.op_pos = p_sat;
              end else if (char_i == slt_pkg::CH_GT) begin
                st.mode = slt_pkg::MODE_GT;
                st.op_pos = p_sat;
              end else if (!is_ws) begin
                st.mode = slt_pkg::MODE_WORD;
                st.tok_start = p_sat;
                res[n] = mk(slt_pkg::EV_CONTENT, slt_pkg::TK_WORD, char_i, p_sat,
                            slt_pkg::ERR_QUOTE);
                n = n + 2'd1;
              end
            end
          endcase
        end
      end

      // Close the line, or start discarding after an error.
      if (failed) begin
        if (eol_i) begin
          st = slt_pkg::ST_RESET;
        end else begin
          st.discard = 1'b1;
        end
      end else if (eol_i) begin
        rtk = slt_pkg::token_kind_t'(3'(slt_pkg::TK_REDIR_IN) + {1'b0, st.redir});
        if (n != 2'd3) begin
          unique case (st.mode)
            slt_pkg::MODE_WORD: begin
              res[n] = mk(slt_pkg::EV_COMPLETE, slt_pkg::TK_WORD, 8'h00,
                          st.tok_start, slt_pkg::ERR_QUOTE);
              n = n + 2'd1;
            end
            slt_pkg::MODE_QUOTED: begin
              res[n] = mk(slt_pkg::EV_ERROR, slt_pkg::TK_WORD, 8'h00,
                          st.tok_start, slt_pkg::ERR_QUOTE);
              n = n + 2'd1;
            end
            slt_pkg::MODE_GT: begin
              res[n] = mk(slt_pkg::EV_ERROR, slt_pkg::TK_WORD, 8'h00, st.op_pos,
                          slt_pkg::ERR_NO_OUTPUT);
              n = n + 2'd1;
            end
            slt_pkg::MODE_RWAIT: begin
              res[n] = mk(slt_pkg::EV_ERROR, slt_pkg::TK_WORD, 8'h00, st.op_pos,
                          (st.redir == slt_pkg::RK_IN) ? slt_pkg::ERR_NO_INPUT
                                                       : slt_pkg::ERR_NO_OUTPUT);
              n = n + 2'd1;
            end
            slt_pkg::MODE_RNAME: begin
              res[n] = mk(slt_pkg::EV_COMPLETE, rtk, 8'h00, st.tok_start,
                          slt_pkg::ERR_QUOTE);
              n = n + 2'd1;
            end
            default: begin
            end
          endcase
        end
        st = slt_pkg::ST_RESET;
      end
    end

    // Mark the final result of this byte.
    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end

    state_nxt = st;
    res_o     = res;
    cnt_o     = n;
  end

endmodule

`default_nettype wire

// ===== src/shell_line_tokenizer.sv =====
// Top level of the shell line tokenizer: line state, step logic and result buffer.
//
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    tdata: char_in; tlast: end_of_line
// out_     out  out_tvalid/out_tready  tdata: token_kind, content_byte, position,
//                                      error_code; tuser: event_kind;
//                                      tlast: last_of_run
//
// A byte is scanned in the cycle it is accepted; its results, up to three, sit
// in a three-entry result register from the next cycle and leave one per cycle
// while out_ is ready. A new byte is taken once the buffer is empty or drains
// its last entry in the same cycle, so bytes enter at one byte per cycle while
// each gives at most one result and out_ is ready; more results block new bytes.
// Reset (rst_n low, synchronous) returns the line state to idle and empties
// the buffer. A stall on out_ holds the head result and blocks new bytes.
`default_nettype none

module shell_line_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_in
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [2:0] token_kind, [10:3] content_byte,
                                       // [22:11] position, [24:23] error_code
  output logic [1:0]       out_tuser,  // [1:0] event_kind
  output logic             out_tlast
);

  slt_pkg::state_t   state_r;
  slt_pkg::state_t   state_nxt;
  slt_pkg::result_t  step_res [slt_pkg::RES_MAX];
  logic [1:0]        step_cnt;
  slt_pkg::result_t  res_r [slt_pkg::RES_MAX];
  logic [1:0]        cnt_r;
  logic              in_acc;
  logic              out_acc;

  // Scan logic for the byte on the input channel.
  slt_step u_step (
    .state_i   (state_r),
    .char_i    (in_tdata),
    .eol_i     (in_tlast),
    .state_nxt (state_nxt),
    .res_o     (step_res),
    .cnt_o     (step_cnt)
  );

  // Accept when the buffer is empty, or its last result leaves this cycle.
  assign in_tready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  // Line state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slt_pkg::ST_RESET;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // Result buffer count: loaded from the step, decremented on each transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (in_acc) begin
      cnt_r <= step_cnt;
    end else if (out_acc) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Result buffer payload: the head is always entry zero.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= step_res;
    end else if (out_acc) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

  // Output channel.
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {7'd0, res_r[0].err, res_r[0].pos, res_r[0].data, res_r[0].tk};
  assign out_tuser  = res_r[0].ev;
  assign out_tlast  = res_r[0].last;

`ifndef ASSERT_OFF
  // The last buffered result of a byte carries the end-of-run mark.
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (cnt_r == 2'd1)) |-> out_tlast)
    else $error("final buffered result lacks last_of_run");

  // An error is always the final result of its byte.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == slt_pkg::EV_ERROR)) |-> out_tlast)
    else $error("error result not last of run");

  // A byte that yields results shows them in the next cycle.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (step_cnt != 2'd0)) |=> (out_tvalid && (cnt_r == $past(step_cnt))))
    else $error("results not loaded into buffer");

  // Bytes of a discarded line give no results.
  a_discard: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && state_r.discard) |-> (step_cnt == 2'd0))
    else $error("discarded byte produced results");

  // The byte counter saturates at the line limit.
  a_bp_sat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.byte_pos <= slt_pkg::BP_W'(slt_pkg::MAX_LINE))
    else $error("byte position beyond line limit");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the shell line tokenizer: byte stream in, token events out.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_HEAVY   = 71;
  localparam int IDLE_LIGHT   = 15;
  localparam int REPORT_MAX   = 40;

  // One byte of a command line as it goes onto the input channel.
  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } line_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] char_in
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [2:0] token_kind, [10:3] content_byte,
                                   // [22:11] position, [24:23] error_code
  logic [1:0]  out_tuser;          // [1:0] event_kind
  logic        out_tlast;

  line_byte_t        unsent_bytes[$];
  slt_pkg::result_t  run_events[$];
  slt_pkg::result_t  due_events[$];
  logic [7:0]        line_buf[$];

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_armed = 1'b0;
  bit          hold_taken = 1'b0;
  int          hold_left = 0;
  int          fail_count = 0;
  int          cycle_count = 0;

  // Line state of the tokenizer as the testbench tracks it.
  slt_pkg::mode_t  scan_mode;
  logic [1:0]      redir_kind;
  logic [11:0]     tok_start;
  logic [11:0]     op_pos;
  int unsigned     line_pos;
  bit              discarding;

  shell_line_tokenizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Token prediction.
  // ---------------------------------------------------------------------------

  function automatic logic [11:0] clip_pos(int unsigned x);
    return (x > 4095) ? 12'd4095 : 12'(x);
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == slt_pkg::CH_SPACE || (c >= slt_pkg::CH_TAB && c <= slt_pkg::CH_CR);
  endfunction

  function automatic bit is_marker(logic [7:0] c);
    return c == slt_pkg::CH_PIPE || c == slt_pkg::CH_LT || c == slt_pkg::CH_GT ||
           c == slt_pkg::CH_QUOTE;
  endfunction

  // Append one event to those the current byte causes.
  function automatic void queue_event(slt_pkg::event_kind_t ev, slt_pkg::token_kind_t tk,
                                      logic [7:0] data, logic [11:0] pos,
                                      slt_pkg::error_code_t err);
    slt_pkg::result_t r;
    r.ev   = ev;
    r.tk   = tk;
    r.data = data;
    r.pos  = pos;
    r.err  = err;
    r.last = 1'b0;
    run_events = {run_events, r};
  endfunction

  function automatic slt_pkg::token_kind_t redir_token();
    return slt_pkg::token_kind_t'(3'(slt_pkg::TK_REDIR_IN) + {1'b0, redir_kind});
  endfunction

  function automatic slt_pkg::error_code_t missing_name_code();
    return (redir_kind == slt_pkg::RK_IN) ? slt_pkg::ERR_NO_INPUT : slt_pkg::ERR_NO_OUTPUT;
  endfunction

  function automatic void clear_line();
    scan_mode  = slt_pkg::MODE_IDLE;
    redir_kind = slt_pkg::RK_IN;
    tok_start  = '0;
    op_pos     = '0;
    line_pos   = 0;
    discarding = 1'b0;
  endfunction

  // Work out the events one accepted byte causes and queue them as due.
  task automatic tokenize_byte(input logic [7:0] c, input logic eol);
    bit          failed;
    bit          again;
    logic [11:0] p;
    failed = 1'b0;
    run_events.delete();
    if (discarding) begin
      if (eol) clear_line();
      return;
    end
    if (line_pos >= slt_pkg::MAX_LINE) begin
      // Too long: the byte itself is not scanned.
      queue_event(slt_pkg::EV_ERROR, slt_pkg::TK_WORD, 8'h00, clip_pos(line_pos),
                  slt_pkg::ERR_TOO_LONG);
      failed = 1'b1;
    end else begin
      p = clip_pos(line_pos);
      line_pos++;
      // A byte that ends a word or name is rescanned from idle; one after a lone '>' is rescanned.
      for (int g = 0; g < 4; g++) begin
        again = 1'b0;
        case (scan_mode)
          slt_pkg::MODE_WORD: begin
            if (is_blank(c) || is_marker(c)) begin
              queue_event(slt_pkg::EV_COMPLETE, slt_pkg::TK_WORD, 8'h00, tok_start,
                          slt_pkg::ERR_QUOTE);
              scan_mode = slt_pkg::MODE_IDLE;
              again = 1'b1;
            end else begin
              queue_event(slt_pkg::EV_CONTENT, slt_pkg::TK_WORD, c, tok_start,
                          slt_pkg::ERR_QUOTE);
            end
          end
          slt_pkg::MODE_QUOTED: begin
            if (c == slt_pkg::CH_QUOTE) begin
              queue_event(slt_pkg::EV_COMPLETE, slt_pkg::TK_QUOTED, 8'h00, tok_start,
                          slt_pkg::ERR_QUOTE);
              scan_mode = slt_pkg::MODE_IDLE;
            end else begin
              queue_event(slt_pkg::EV_CONTENT, slt_pkg::TK_QUOTED, c, tok_start,
                          slt_pkg::ERR_QUOTE);
            end
          end
          slt_pkg::MODE_GT: begin
            scan_mode = slt_pkg::MODE_RWAIT;
            if (c == slt_pkg::CH_GT) begin
              redir_kind = slt_pkg::RK_APPEND;
            end else begin
              redir_kind = slt_pkg::RK_TRUNC;
              again = 1'b1;
            end
          end
          slt_pkg::MODE_RWAIT: begin
            if (is_marker(c)) begin
              queue_event(slt_pkg::EV_ERROR, slt_pkg::TK_WORD, 8'h00, op_pos,
                          missing_name_code());
              failed = 1'b1;
            end else if (!is_blank(c)) begin
              scan_mode = slt_pkg::MODE_RNAME;
              tok_start = p;
              queue_event(slt_pkg::EV_CONTENT, redir_token(), c, tok_start,
                          slt_pkg::ERR_QUOTE);
            end
          end
          slt_pkg::MODE_RNAME: begin
            if (is_blank(c) || is_marker(c)) begin
              queue_event(slt_pkg::EV_COMPLETE, redir_token(), 8'h00, tok_start,
                          slt_pkg::ERR_QUOTE);
              scan_mode = slt_pkg::MODE_IDLE;
              again = 1'b1;
            end else begin
              queue_event(slt_pkg::EV_CONTENT, redir_token(), c, tok_start,
                          slt_pkg::ERR_QUOTE);
            end
          end
          default: begin
            scan_mode = slt_pkg::MODE_IDLE;
            if (c == slt_pkg::CH_QUOTE) begin
              scan_mode = slt_pkg::MODE_QUOTED;
              tok_start = p;
            end else if (c == slt_pkg::CH_PIPE) begin
              queue_event(slt_pkg::EV_COMPLETE, slt_pkg::TK_PIPE, 8'h00, p,
                          slt_pkg::ERR_QUOTE);
            end else if (c == slt_pkg::CH_LT) begin
              scan_mode  = slt_pkg::MODE_RWAIT;
              redir_kind = slt_pkg::RK_IN;
              op_pos     = p;
            end else if (c == slt_pkg::CH_GT) begin
              scan_mode = slt_pkg::MODE_GT;
              op_pos    = p;
            end else if (!is_blank(c)) begin
              scan_mode = slt_pkg::MODE_WORD;
              tok_start = p;
              queue_event(slt_pkg::EV_CONTENT, slt_pkg::TK_WORD, c, tok_start,
                          slt_pkg::ERR_QUOTE);
            end
          end
        endcase
        if (!again) break;
      end
    end

    // End of line: close an open token or report what is left unfinished.
    if (failed) begin
      if (eol) clear_line();
      else discarding = 1'b1;
    end else if (eol) begin
      case (scan_mode)
        slt_pkg::MODE_WORD:
          queue_event(slt_pkg::EV_COMPLETE, slt_pkg::TK_WORD, 8'h00, tok_start,
                      slt_pkg::ERR_QUOTE);
        slt_pkg::MODE_QUOTED:
          queue_event(slt_pkg::EV_ERROR, slt_pkg::TK_WORD, 8'h00, tok_start,
                      slt_pkg::ERR_QUOTE);
        slt_pkg::MODE_GT:
          queue_event(slt_pkg::EV_ERROR, slt_pkg::TK_WORD, 8'h00, op_pos,
                      slt_pkg::ERR_NO_OUTPUT);
        slt_pkg::MODE_RWAIT:
          queue_event(slt_pkg::EV_ERROR, slt_pkg::TK_WORD, 8'h00, op_pos,
                      missing_name_code());
        slt_pkg::MODE_RNAME:
          queue_event(slt_pkg::EV_COMPLETE, redir_token(), 8'h00, tok_start,
                      slt_pkg::ERR_QUOTE);
        default: ;
      endcase
      clear_line();
    end

    while (run_events.size() > slt_pkg::RES_MAX) void'(run_events.pop_back());
    if (run_events.size() > 0) run_events[run_events.size() - 1].last = 1'b1;
    due_events = {due_events, run_events};
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: feeds queued bytes, predicting on each accepted transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_input
    line_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) tokenize_byte(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (unsent_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = unsent_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.ch;
          in_tlast  <= nxt.eol;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, with one long hold-off when armed.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_armed && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: compares each result transaction with the oldest due event.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch_output
    slt_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_events.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $error("result with nothing due: tdata %h, tuser %0d", out_tdata, out_tuser);
      end else begin
        want = due_events.pop_front();
        check_field("event_kind",   want.ev,   out_tuser);
        check_field("token_kind",   want.tk,   out_tdata[2:0]);
        check_field("content_byte", want.data, out_tdata[10:3]);
        check_field("position",     want.pos,  out_tdata[22:11]);
        check_field("error_code",   want.err,  out_tdata[24:23]);
        check_field("last_of_run",  want.last, out_tlast);
        check_field("tdata padding", 0,        out_tdata[31:25]);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Line construction.
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] c, input logic eol);
    line_byte_t b;
    b.ch  = c;
    b.eol = eol;
    unsent_bytes = {unsent_bytes, b};
  endtask

  task automatic add_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], close && (i == s.len() - 1));
  endtask

  function automatic void put_byte(logic [7:0] c);
    line_buf = {line_buf, c};
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(0, 1) ? slt_pkg::CH_SPACE
                                : 8'($urandom_range(slt_pkg::CH_TAB, slt_pkg::CH_CR));
  endfunction

  function automatic logic [7:0] pick_name_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_blank(c) || is_marker(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_quoted_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == slt_pkg::CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] pick_marker();
    case ($urandom_range(0, 3))
      0:       return slt_pkg::CH_PIPE;
      1:       return slt_pkg::CH_LT;
      2:       return slt_pkg::CH_GT;
      default: return slt_pkg::CH_QUOTE;
    endcase
  endfunction

  task automatic put_blanks(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) put_byte(pick_blank());
  endtask

  task automatic put_name(input int hi);
    repeat ($urandom_range(1, hi)) put_byte(pick_name_byte());
  endtask

  task automatic put_operator(input slt_pkg::token_kind_t k);
    case (k)
      slt_pkg::TK_REDIR_IN:    put_byte(slt_pkg::CH_LT);
      slt_pkg::TK_REDIR_TRUNC: put_byte(slt_pkg::CH_GT);
      default: begin
        put_byte(slt_pkg::CH_GT);
        put_byte(slt_pkg::CH_GT);
      end
    endcase
  endtask

  task automatic put_token();
    slt_pkg::token_kind_t k;
    k = slt_pkg::token_kind_t'($urandom_range(slt_pkg::TK_WORD, slt_pkg::TK_REDIR_APPEND));
    case (k)
      slt_pkg::TK_WORD: put_name(6);
      slt_pkg::TK_QUOTED: begin
        put_byte(slt_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 5)) put_byte(pick_quoted_byte());
        put_byte(slt_pkg::CH_QUOTE);
      end
      slt_pkg::TK_PIPE: put_byte(slt_pkg::CH_PIPE);
      default: begin
        put_operator(k);
        put_blanks(0, 2);
        put_name(5);
      end
    endcase
  endtask

  // A broken ending: open quote, operator with no name, or operator then marker.
  task automatic put_fault();
    case ($urandom_range(0, 2))
      0: begin
        put_byte(slt_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 4)) put_byte(pick_quoted_byte());
      end
      1: begin
        put_operator(slt_pkg::token_kind_t'($urandom_range(slt_pkg::TK_REDIR_IN,
                                                           slt_pkg::TK_REDIR_APPEND)));
        put_blanks(0, 2);
      end
      default: begin
        put_operator(slt_pkg::token_kind_t'($urandom_range(slt_pkg::TK_REDIR_IN,
                                                           slt_pkg::TK_REDIR_APPEND)));
        put_blanks(0, 2);
        put_byte(pick_marker());
        put_token();
      end
    endcase
  endtask

  task automatic send_line();
    foreach (line_buf[i]) add_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  // Mostly well-formed lines, some broken ones and some raw noise.
  task automatic add_traffic(input int n_bytes);
    int total;
    int kind;
    total = 0;
    while (total < n_bytes) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        repeat ($urandom_range(1, 5)) begin
          put_blanks(0, 2);
          put_token();
        end
        if ($urandom_range(0, 3) == 0) put_blanks(1, 2);
      end else if (kind < 90) begin
        repeat ($urandom_range(0, 3)) begin
          put_token();
          put_blanks(1, 2);
        end
        put_fault();
      end else begin
        repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(0, 255)));
      end
      total += line_buf.size();
      send_line();
    end
  endtask

  // Wait until every byte is sent and every due event has arrived.
  task automatic wait_quiet();
    while (unsent_bytes.size() > 0 || in_tvalid || due_events.size() > 0) @(negedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_bytes);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    add_traffic(n_bytes);
    wait_quiet();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------------
  initial begin
    clear_line();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed lines: byte extremes, every token kind and each error but line length.
    add_byte(8'hFF, 1'b0);
    add_text(">> f|\"< \"", 1'b0);
    add_byte(8'h00, 1'b1);
    add_text("<x>y", 1'b1);
    add_text("< |z", 1'b1);
    add_text(">", 1'b1);
    add_text("\"ab", 1'b1);
    add_text(">>\"", 1'b1);
    add_text("<", 1'b1);
    wait_quiet();

    // A line that overruns the length limit, then a discarded tail.
    for (int i = 0; i < slt_pkg::MAX_LINE - 1; i++) add_byte(pick_blank(), 1'b0);
    add_byte("w", 1'b0);
    add_byte("x", 1'b0);
    add_byte("y", 1'b0);
    add_byte("z", 1'b1);
    wait_quiet();

    run_phase(0, 0, 80);
    run_phase(IDLE_HEAVY, 0, 80);
    run_phase(0, IDLE_HEAVY, 80);
    run_phase(IDLE_LIGHT, IDLE_LIGHT, 80);

    // Long receiver hold-off while the sender keeps offering bytes.
    hold_armed = 1'b1;
    run_phase(0, 0, 60);
    hold_armed = 1'b0;

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (due_events.size() != 0) begin
      fail_count++;
      $error("%0d events still due at the end", due_events.size());
    end
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
